### src/assert_macros.svh
// Assertion macros used by the top level of the bounded ordered list.
// Depends on nothing; each macro expects a clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger implies a consequence at the clock after it.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

### src/bol_pkg.sv
// Types and constants of the bounded ordered list.
// Used by the cell, the top level and the bench; depends on nothing.
package bol_pkg;

  localparam int VAL_W = 3;  // stored value
  localparam int POS_W = 5;  // position field
  localparam int LEN_W = 5;  // length field
  localparam int CTL_W = 9;  // holds any index or count up to 256 entries

  typedef enum logic [2:0] {
    FN_PUSH_FRONT   = 3'd0,
    FN_PUSH_BACK    = 3'd1,
    FN_INSERT_AT    = 3'd2,
    FN_DELETE_FRONT = 3'd3,
    FN_DELETE_BACK  = 3'd4,
    FN_DELETE_AT    = 3'd5,
    FN_READ_AT      = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    cell_op_t             op;
    logic [CTL_W-1:0]     pos;
    logic [CTL_W-1:0]     cnt;
    logic [VAL_W-1:0]     value;
  } cell_ctl_t;

  typedef struct packed {
    status_t              status;
    logic [LEN_W-1:0]     length;
    logic [VAL_W-1:0]     read_value;
  } result_t;

endpackage

### src/bounded_ordered_list_core.sv
// Top level of the bounded ordered list: control, row of cells, output buffer.
// Depends on bol_pkg, bol_cell, bol_skid and assert_macros.svh.
// Usage:
//   The input channel (in_*) takes one operation per item: func in in_tuser,
//   value and position in in_tdata. The result channel (out_*) returns exactly
//   one item per operation: status in out_tuser, length and the read value in
//   out_tdata. Results leave in the order the operations arrived.
// Throughput:
//   One item per cycle while out_tready stays high. A result is registered in
//   the output register, or in the skid slot while the receiver stalls. The row
//   of cells moves every entry by at most one place on each update, so the
//   update of one operation is done before the next one is evaluated; reads look
//   at the first 32 cells only, since the position field cannot reach further.
// Stall:
//   When the receiver holds out_tready low, the result waits in the output
//   register and one more item is still accepted into the skid slot; after
//   that in_tready drops until the receiver takes a result.
// Reset: rst_n low empties the list (length zero) and the output buffer;
//   in_tready stays low while reset is held. Cell contents are not cleared:
//   only entries below the length are ever read.
module bounded_ordered_list_core
  import bol_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [2:0] value, [7:3] position
  input  logic [2:0] in_tuser,   // [2:0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [4:0] length, [7:5] read_value
  output logic [1:0] out_tuser   // [1:0] status
);

  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RD_CELLS = (CAPACITY < 32) ? CAPACITY : 32;
  localparam logic [CTL_W-1:0] CAP_C = CTL_W'(CAPACITY);

  logic [CNT_W-1:0] count_r, count_nxt;

  logic             buf_ready;
  logic             accept;
  func_t            fn;
  logic [VAL_W-1:0] in_value;
  logic [POS_W-1:0] in_pos;
  logic [CTL_W-1:0] pos9, cnt9, cnt_after;
  logic [VAL_W-1:0] rd_sel;
  cell_ctl_t        ctl;
  result_t          res;
  result_t          buf_out;
  status_t          st;
  logic [VAL_W-1:0] rd;
  logic [VAL_W-1:0] vals [CAPACITY];

  assign in_tready = rst_n && buf_ready;
  assign accept    = in_tvalid && in_tready;
  assign fn        = func_t'(in_tuser);
  assign in_value  = in_tdata[2:0];
  assign in_pos    = in_tdata[7:3];
  assign pos9      = CTL_W'(in_pos);
  assign cnt9      = CTL_W'(count_r);

  // Pick the addressed entry for a read; positions above 31 cannot occur
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < RD_CELLS; i++) begin
      if (in_pos == POS_W'(i)) begin
        rd_sel = vals[i];
      end
    end
  end

  // Decode the operation, check full, empty and range, and drive the row
  always_comb begin
    st        = ST_OK;
    rd        = '0;
    cnt_after = cnt9;
    ctl.op    = CELL_HOLD;
    ctl.pos   = '0;
    ctl.cnt   = cnt9;
    ctl.value = in_value;
    case (fn)
      FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT_AT: begin
        if (cnt9 >= CAP_C) begin
          st = ST_FULL;
        end else if (fn == FN_INSERT_AT && pos9 > cnt9) begin
          st = ST_RANGE;
        end else begin
          ctl.op    = CELL_INSERT;
          ctl.pos   = (fn == FN_PUSH_FRONT) ? '0 : (fn == FN_PUSH_BACK) ? cnt9 : pos9;
          cnt_after = cnt9 + CTL_W'(1);
        end
      end
      FN_DELETE_FRONT, FN_DELETE_BACK, FN_DELETE_AT, FN_READ_AT: begin
        if (cnt9 == '0) begin
          st = ST_EMPTY;
        end else if ((fn == FN_DELETE_AT || fn == FN_READ_AT) && pos9 >= cnt9) begin
          st = ST_RANGE;
        end else if (fn == FN_READ_AT) begin
          rd = rd_sel;
        end else begin
          ctl.op    = CELL_DELETE;
          ctl.pos   = (fn == FN_DELETE_FRONT) ? '0 :
                      (fn == FN_DELETE_BACK) ? cnt9 - CTL_W'(1) : pos9;
          cnt_after = cnt9 - CTL_W'(1);
        end
      end
      default: ;
    endcase
    // hold the row unless an item is taken this cycle
    if (!accept) begin
      ctl.op = CELL_HOLD;
    end
  end

  assign res.status     = st;
  assign res.length     = cnt_after[LEN_W-1:0];
  assign res.read_value = rd;

  assign count_nxt = accept ? CNT_W'(cnt_after) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Row of cells; each one sees its two neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = vals[g+1];
    end
    bol_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (vals[g])
    );
  end

  bol_skid #(.W($bits(result_t))) u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (accept),
    .push_ready (buf_ready),
    .push_data  (res),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (buf_out)
  );

  assign out_tdata = {buf_out.read_value, buf_out.length};
  assign out_tuser = buf_out.status;

`include "assert_macros.svh"

  `ASSERT_CLK(a_count_bound, count_r <= CNT_W'(CAPACITY), "length above capacity")
  `ASSERT_NEXT(a_fail_holds, accept && res.status != ST_OK, $stable(count_r),
               "failed op changed length")
  `ASSERT_NEXT(a_insert_grows, accept && ctl.op == CELL_INSERT,
               count_r == $past(count_r) + CNT_W'(1), "insert did not grow list")
  `ASSERT_NEXT(a_delete_shrinks, accept && ctl.op == CELL_DELETE,
               count_r == $past(count_r) - CNT_W'(1), "delete did not shrink list")

endmodule

### src/bol_cell.sv
// One entry of the list row: holds a value and shifts with its neighbors.
// Depends on bol_pkg for the broadcast control struct.
module bol_cell
  import bol_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [VAL_W-1:0] left_val,
  input  logic [VAL_W-1:0] right_val,
  output logic [VAL_W-1:0] val
);

  localparam logic [CTL_W-1:0] MY_IDX  = CTL_W'(IDX);
  localparam logic [CTL_W-1:0] MY_IDX1 = CTL_W'(IDX + 1);

  logic [VAL_W-1:0] cell_r;
  logic [VAL_W-1:0] cell_nxt;

  always_comb begin
    cell_nxt = cell_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (MY_IDX == ctl.pos) begin
          cell_nxt = ctl.value;
        end else if (MY_IDX > ctl.pos && MY_IDX <= ctl.cnt) begin
          cell_nxt = left_val;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= ctl.pos && MY_IDX1 < ctl.cnt) begin
          cell_nxt = right_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign val = cell_r;

endmodule

### src/bol_skid.sv
// Two-entry output buffer: an output register plus one skid slot.
// Depends on nothing; the payload width is a parameter.
module bol_skid #(
  parameter int W = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  logic [W-1:0] out_data_r, out_data_nxt;
  logic [W-1:0] skid_data_r, skid_data_nxt;

  assign push_ready = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push_valid;
        out_data_nxt  = push_data;
      end
    end else if (push_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign pop_valid = out_valid_r;
  assign pop_data  = out_data_r;

endmodule

### bench/tb_top.sv
// Self-checking bench for bounded_ordered_list_core: a shadow list predicts each result.
// Depends on bol_pkg and the RTL of the bounded ordered list; reads no files.
`timescale 1ns / 1ps

module tb_top;
  import bol_pkg::*;

  localparam int CAPACITY = 16;
  localparam int CYCLE_LIMIT = 60000;
  localparam logic [2:0] FN_UNUSED = 3'd7;  // func code with no operation behind it

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;    // [2:0] value, [7:3] position
  logic [2:0] in_tuser = '0;    // [2:0] func
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;        // [4:0] length, [7:5] read_value
  logic [1:0] out_tuser;        // [1:0] status

  // Shadow copy of the list, updated as each item is accepted
  logic [VAL_W-1:0] list_vals [CAPACITY];
  int               list_len = 0;

  result_t pending_results [$];
  int      items_taken = 0;
  int      errors = 0;
  int      cycle_count = 0;
  bit      idle_on = 1'b1;
  int      result_holdoff = 0;

  bounded_ordered_list_core #(.CAPACITY(CAPACITY)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one operation to the shadow list and return the result it must produce.
  function automatic result_t apply_list_op(input logic [2:0] op, input logic [2:0] val,
                                            input logic [4:0] pos);
    result_t res;
    int      at;
    int      i;
    res.status     = ST_OK;
    res.read_value = '0;
    case (op)
      FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT_AT: begin
        // a full list refuses before the index is looked at
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (op == FN_INSERT_AT && int'(pos) > list_len) begin
          res.status = ST_RANGE;
        end else begin
          at = (op == FN_PUSH_FRONT) ? 0 : (op == FN_PUSH_BACK) ? list_len : int'(pos);
          for (i = list_len; i > at; i--) list_vals[i] = list_vals[i-1];
          list_vals[at] = val;
          list_len++;
        end
      end
      FN_DELETE_FRONT, FN_DELETE_BACK, FN_DELETE_AT, FN_READ_AT: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if ((op == FN_DELETE_AT || op == FN_READ_AT) && int'(pos) >= list_len) begin
          res.status = ST_RANGE;
        end else if (op == FN_READ_AT) begin
          res.read_value = list_vals[pos];
        end else begin
          at = (op == FN_DELETE_FRONT) ? 0 : (op == FN_DELETE_BACK) ? list_len - 1 : int'(pos);
          for (i = at; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      default: ;  // unused code: nothing changes
    endcase
    res.length = list_len[LEN_W-1:0];
    return res;
  endfunction

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Sample both handshakes at the rising edge: check results, then predict new items.
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0d length %0d value %0d",
                   $time, out_tuser, out_tdata[4:0], out_tdata[7:5]);
          errors++;
        end else begin
          want = pending_results.pop_front();
          report_field("status", want.status, out_tuser);
          report_field("length", want.length, out_tdata[4:0]);
          report_field("read_value", want.read_value, out_tdata[7:5]);
        end
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_list_op(in_tuser, in_tdata[2:0], in_tdata[7:3]));
        items_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: a long hold-off when asked, otherwise random stall bursts while idling is on.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (result_holdoff > 0) begin
        result_holdoff--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one item, with an optional random gap first, and hold it until accepted.
  task automatic send_op(input logic [2:0] op, input logic [2:0] val, input logic [4:0] pos);
    int target;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    target = items_taken + 1;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pos, val};
    wait (items_taken == target);
  endtask

  // Every removal and the read on an empty list, the unused code, insert past the end.
  task automatic test_empty_list;
    send_op(FN_DELETE_FRONT, 3'd0, 5'd0);
    send_op(FN_DELETE_BACK, 3'd0, 5'd0);
    send_op(FN_DELETE_AT, 3'd0, 5'd0);
    send_op(FN_READ_AT, 3'd0, 5'd0);
    send_op(FN_UNUSED, 3'd7, 5'd31);
    send_op(FN_INSERT_AT, 3'd2, 5'd1);
  endtask

  // Grow to capacity through every insert kind, then push against the full list.
  task automatic test_fill_and_full;
    int k;
    send_op(FN_PUSH_BACK, 3'd0, 5'd0);
    send_op(FN_PUSH_FRONT, 3'd1, 5'd0);
    send_op(FN_INSERT_AT, 3'd2, 5'd1);
    send_op(FN_INSERT_AT, 3'd3, 5'd3);
    send_op(FN_PUSH_BACK, 3'd4, 5'd0);
    send_op(FN_PUSH_FRONT, 3'd7, 5'd0);  // top value of the 3-bit field is kept as is
    for (k = 6; k < CAPACITY; k++) send_op(FN_INSERT_AT, 3'(k), 5'(k / 2));
    send_op(FN_PUSH_FRONT, 3'd1, 5'd0);
    send_op(FN_PUSH_BACK, 3'd2, 5'd0);
    send_op(FN_INSERT_AT, 3'd3, 5'd31);  // full wins over the bad index
  endtask

  // Last valid index, one past it, the top of the position field, then the end removals.
  task automatic test_index_limits;
    send_op(FN_READ_AT, 3'd0, 5'(CAPACITY - 1));
    send_op(FN_READ_AT, 3'd0, 5'(CAPACITY));
    send_op(FN_DELETE_AT, 3'd0, 5'd31);
    send_op(FN_DELETE_BACK, 3'd0, 5'd0);
    send_op(FN_DELETE_FRONT, 3'd0, 5'd0);
  endtask

  // Mostly well-formed operations; the mix swings between growing and shrinking
  // so the list keeps passing through both empty and full.
  task automatic test_random_ops(input int n_items);
    int         k;
    int         roll;
    bit         grow;
    logic [2:0] op;
    logic [2:0] val;
    logic [4:0] pos;
    grow = 1'b0;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) grow = ~grow;
      roll = $urandom_range(0, 99);
      if (roll < 2) op = FN_UNUSED;
      else if (roll < 12) op = FN_READ_AT;
      else if ((roll < 70) == grow) op = 3'($urandom_range(FN_PUSH_FRONT, FN_INSERT_AT));
      else op = 3'($urandom_range(FN_DELETE_FRONT, FN_DELETE_AT));
      val = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if ($urandom_range(0, 9) == 0) pos = 5'($urandom_range(0, 31));
      else if (op <= FN_INSERT_AT) pos = 5'($urandom_range(0, list_len));
      else pos = (list_len > 0) ? 5'($urandom_range(0, list_len - 1)) : 5'd0;
      send_op(op, val, pos);
    end
  endtask

  // Hold the receiver off long enough for the block to fill and stall its input.
  task automatic test_input_backpressure;
    int k;
    result_holdoff = 40;
    for (k = 0; k < 24; k++) begin
      if (k % 2 == 0) send_op(FN_PUSH_BACK, 3'($urandom_range(0, 4)), 5'd0);
      else send_op(FN_READ_AT, 3'd0, (list_len > 0) ? 5'($urandom_range(0, list_len - 1)) : 5'd0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_fill_and_full();
    test_index_limits();
    test_random_ops(420);
    test_input_backpressure();
    // drop all idling for the final stretch
    idle_on = 1'b0;
    test_random_ops(80);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/bol_pkg.sv
src/bol_cell.sv
src/bol_skid.sv
src/bounded_ordered_list_core.sv
bench/tb_top.sv
